// ===== design/self_organizing_list_search_macros.svh =====
// Assertion helpers used by the top design file.
`ifndef SELF_ORGANIZING_LIST_SEARCH_MACROS_SVH
`define SELF_ORGANIZING_LIST_SEARCH_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SOLS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, held off during reset.
`define SOLS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ===== design/sols_pkg.sv =====
`timescale 1ns / 1ps
package sols_pkg;

   localparam logic [1:0] CMD_SEARCH = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   localparam logic [2:0] STRAT_TRANSPOSE = 3'd0;
   localparam logic [2:0] STRAT_MOVE_FRONT = 3'd1;
   localparam logic [2:0] STRAT_K_SWAP    = 3'd2;
   localparam logic [2:0] STRAT_K_MOVE    = 3'd3;
   localparam logic [2:0] STRAT_COUNT     = 3'd4;
   localparam logic [2:0] STRAT_HYBRID    = 3'd5;

   localparam logic [2:0] CSR_STRATEGY = 3'd0;
   localparam logic [2:0] CSR_K_FRAC   = 3'd1;
   localparam logic [2:0] CSR_RUN_LIM  = 3'd2;
   localparam logic [2:0] CSR_WINDOW   = 3'd3;
   localparam logic [2:0] CSR_LENGTH   = 3'd4;

   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_SHIFT  = 3'd1;
   localparam logic [2:0] OP_SWAP   = 3'd2;
   localparam logic [2:0] OP_INSERT = 3'd3;
   localparam logic [2:0] OP_DELETE = 3'd4;
   localparam logic [2:0] OP_CLEAR  = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic signed [31:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] position;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic        valid;
      logic [15:0] hits;
   } entry_type;

endpackage

// ===== design/sols_cell.sv =====
`timescale 1ns / 1ps
module sols_cell #(
   parameter int IDX_W = 6,
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          op_kind,
   input  logic [IDX_W-1:0]    op_lo,
   input  logic [IDX_W-1:0]    op_hi,
   input  sols_pkg::entry_type carry_ent,
   input  sols_pkg::entry_type other_ent,
   input  sols_pkg::entry_type left_ent,
   input  logic [31:0]         cmp_key,
   output sols_pkg::entry_type ent,
   output logic                match
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [31:0] key_ff, key_in;
   logic        valid_ff, valid_in;
   logic [15:0] hits_ff, hits_in;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      hits_in  = hits_ff;
      case (op_kind)
         sols_pkg::OP_SHIFT: begin
            if (MY_IDX == op_lo) begin
               {key_in, valid_in, hits_in} = carry_ent;
            end else if (MY_IDX > op_lo && MY_IDX <= op_hi) begin
               {key_in, valid_in, hits_in} = left_ent;
            end
         end
         sols_pkg::OP_SWAP: begin
            if (MY_IDX == op_lo) begin
               {key_in, valid_in, hits_in} = carry_ent;
            end else if (MY_IDX == op_hi) begin
               {key_in, valid_in, hits_in} = other_ent;
            end
         end
         sols_pkg::OP_INSERT: begin
            if (MY_IDX == op_lo) begin
               key_in   = cmp_key;
               valid_in = 1'b1;
            end
         end
         sols_pkg::OP_DELETE: begin
            if (MY_IDX == op_lo) begin
               valid_in = 1'b0;
            end
         end
         sols_pkg::OP_CLEAR: begin
            hits_in = 16'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hits_ff  <= 16'd0;
      end else begin
         valid_ff <= valid_in;
         hits_ff  <= hits_in;
      end
   end

   assign ent   = '{key: key_ff, valid: valid_ff, hits: hits_ff};
   assign match = valid_ff && (key_ff == cmp_key);

endmodule

// ===== design/self_organizing_list_search.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                  Transfer when
// request   start, busy, req_item                  start high and busy low
// result    rsp_valid, rsp_item                    rsp_valid high (one cycle)
// config    csr_valid, csr_ready, csr_index/data   csr_valid and csr_ready high
//
// Every command passes from the accepting edge to the edge that takes the result
// through scan, first-hit encode, plan and apply. Busy holds through those
// states, so no new transfer is taken until busy has dropped after the strobe.
// A move is done by the whole row in the apply cycle. Reset is synchronous and
// clears the valid marks, hit counts and the run count at once; keys stay
// undefined until written. The receiver cannot stall: the result is shown for
// exactly one cycle and busy drops after it.
`include "self_organizing_list_search_macros.svh"
module self_organizing_list_search #(
   parameter int TABLE_SLOTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sols_pkg::req_type req_item,
   output logic              rsp_valid,
   output sols_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int LW    = ($clog2(TABLE_SLOTS + 1) > 7) ? $clog2(TABLE_SLOTS + 1) : 7;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_FIND  = 3'd2;
   localparam logic [2:0] S_PLAN  = 3'd3;
   localparam logic [2:0] S_APPLY = 3'd4;

   // configuration registers
   logic [2:0]  strategy_ff;
   logic [7:0]  k_frac_ff;
   logic [15:0] run_limit_ff;
   logic [6:0]  window_ff;
   logic [6:0]  length_ff;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  cmd_ff;
   logic [31:0] key_ff;
   logic [TABLE_SLOTS-1:0] hit_vec_ff;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic        found_ff, found_in;
   logic [15:0] run_ff;

   // plan results
   logic [2:0]       op_kind_ff, op_kind_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [15:0]      carry_hits_ff, carry_hits_in;
   logic [1:0]       status_ff, status_in;

   sols_pkg::entry_type cell_ent [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0] match_vec;
   logic [TABLE_SLOTS-1:0] in_use;
   logic [LW-1:0]          used_len;

   logic [2:0]          op_kind_act;
   sols_pkg::entry_type carry_ent;
   sols_pkg::entry_type other_ent;
   sols_pkg::entry_type pos_ent;

   logic [IDX_W+7:0] k_prod;
   logic [IDX_W-1:0] k_tgt;
   logic [15:0]      hits_inc;
   logic [15:0]      pos16;
   logic [15:0]      run_in;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff  <= 3'd0;
         k_frac_ff    <= 8'd0;
         run_limit_ff <= 16'd0;
         window_ff    <= 7'd0;
         length_ff    <= 7'd64;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sols_pkg::CSR_STRATEGY: strategy_ff  <= csr_data[2:0];
            sols_pkg::CSR_K_FRAC:   k_frac_ff    <= csr_data[7:0];
            sols_pkg::CSR_RUN_LIM:  run_limit_ff <= csr_data;
            sols_pkg::CSR_WINDOW:   window_ff    <= csr_data[6:0];
            sols_pkg::CSR_LENGTH:   length_ff    <= csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   // cap the active length at the table size
   assign used_len = (LW'(length_ff) > LW'(TABLE_SLOTS)) ? LW'(TABLE_SLOTS) : LW'(length_ff);

   // row of slot cells; on a shift each cell past the target, up to the hit, takes its left neighbour
   for (genvar gi = 0; gi < TABLE_SLOTS; gi++) begin : g_cell
      sols_pkg::entry_type left_ent;
      if (gi == 0) begin : g_head
         assign left_ent = '0;
      end else begin : g_body
         assign left_ent = cell_ent[gi-1];
      end
      assign in_use[gi] = (LW'(gi) < used_len);
      sols_cell #(.IDX_W(IDX_W), .INDEX(gi)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .op_kind   (op_kind_act),
         .op_lo     (lo_ff),
         .op_hi     (pos_ff),
         .carry_ent (carry_ent),
         .other_ent (other_ent),
         .left_ent  (left_ent),
         .cmp_key   (key_ff),
         .ent       (cell_ent[gi]),
         .match     (match_vec[gi])
      );
   end

   // hold the scan result: matches for search/delete, free slots for insert
   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            hit_vec_ff[i] <= in_use[i] &&
               ((cmd_ff == sols_pkg::CMD_INSERT) ? !cell_ent[i].valid : match_vec[i]);
         end
      end
   end

   // first set bit from the front
   always_comb begin
      pos_in   = '0;
      found_in = 1'b0;
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
         if (hit_vec_ff[i]) begin
            pos_in   = IDX_W'(i);
            found_in = 1'b1;
         end
      end
   end

   assign pos_ent  = cell_ent[pos_ff];
   assign k_prod   = (IDX_W+8)'(k_frac_ff) * (IDX_W+8)'(pos_ff);
   assign k_tgt    = k_prod[IDX_W+7:8];
   assign hits_inc = (pos_ent.hits == 16'hFFFF) ? pos_ent.hits : pos_ent.hits + 16'd1;
   assign pos16    = 16'(pos_ff);

   // plan the move from the hit position and the strategy
   always_comb begin
      op_kind_in    = sols_pkg::OP_NONE;
      lo_in         = pos_ff;
      carry_hits_in = pos_ent.hits;
      status_in     = sols_pkg::ST_OK;
      run_in        = run_ff;
      case (cmd_ff)
         sols_pkg::CMD_SEARCH: begin
            if (!found_ff) begin
               status_in = sols_pkg::ST_NOT_FOUND;
            end else begin
               case (strategy_ff)
                  sols_pkg::STRAT_MOVE_FRONT: begin
                     op_kind_in = sols_pkg::OP_SHIFT;
                     lo_in      = '0;
                  end
                  sols_pkg::STRAT_K_SWAP: begin
                     op_kind_in = sols_pkg::OP_SWAP;
                     lo_in      = k_tgt;
                  end
                  sols_pkg::STRAT_K_MOVE: begin
                     op_kind_in = sols_pkg::OP_SHIFT;
                     lo_in      = k_tgt;
                  end
                  sols_pkg::STRAT_COUNT: begin
                     op_kind_in    = sols_pkg::OP_SHIFT;
                     carry_hits_in = hits_inc;
                     lo_in = (pos16 >= hits_inc) ? IDX_W'(pos16 - hits_inc) : '0;
                  end
                  sols_pkg::STRAT_HYBRID: begin
                     if (run_ff < run_limit_ff) begin
                        op_kind_in = sols_pkg::OP_SHIFT;
                        lo_in      = '0;
                        if ((11'(pos_ff) + 11'd1) <= 11'(window_ff)) begin
                           run_in = (run_ff == 16'hFFFF) ? run_ff : run_ff + 16'd1;
                        end else begin
                           run_in = 16'd0;
                        end
                     end else begin
                        op_kind_in = sols_pkg::OP_SWAP;
                        lo_in      = k_tgt;
                     end
                  end
                  default: begin
                     // transpose, also for the unused codes
                     if (pos_ff != '0) begin
                        op_kind_in = sols_pkg::OP_SWAP;
                        lo_in      = pos_ff - IDX_W'(1);
                     end
                  end
               endcase
            end
         end
         sols_pkg::CMD_INSERT: begin
            if (found_ff) begin
               op_kind_in = sols_pkg::OP_INSERT;
            end else begin
               status_in = sols_pkg::ST_FULL;
            end
         end
         sols_pkg::CMD_DELETE: begin
            if (found_ff) begin
               op_kind_in = sols_pkg::OP_DELETE;
            end else begin
               status_in = sols_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            op_kind_in = sols_pkg::OP_CLEAR;
         end
      endcase
   end

   // broadcast the move to the row in the apply cycle only
   assign op_kind_act = (state_ff == S_APPLY) ? op_kind_ff : sols_pkg::OP_NONE;
   assign carry_ent   = '{key: pos_ent.key, valid: pos_ent.valid, hits: carry_hits_ff};
   assign other_ent   = cell_ent[lo_ff];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (start) state_in = S_SCAN;
         S_SCAN:  state_in = S_FIND;
         S_FIND:  state_in = S_PLAN;
         S_PLAN:  state_in = S_APPLY;
         S_APPLY: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         run_ff   <= 16'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_PLAN) begin
            run_ff <= run_in;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         cmd_ff <= req_item.cmd;
         key_ff <= req_item.key;
      end
      if (state_ff == S_FIND) begin
         pos_ff   <= pos_in;
         found_ff <= found_in;
      end
      if (state_ff == S_PLAN) begin
         op_kind_ff    <= op_kind_in;
         lo_ff         <= lo_in;
         carry_hits_ff <= carry_hits_in;
         status_ff     <= status_in;
      end
   end

   // result strobe in the apply cycle; position drops to zero on failure and for clear
   assign rsp_valid         = (state_ff == S_APPLY);
   assign rsp_item.status   = status_ff;
   assign rsp_item.position = ((status_ff == sols_pkg::ST_OK) &&
                               (cmd_ff != sols_pkg::CMD_CLEAR)) ? 6'(pos_ff) : 6'd0;

   `SOLS_ASSERT_NEXT(a_strobe_then_idle, clock, reset, rsp_valid, !busy && !rsp_valid)
   `SOLS_ASSERT_NOW(a_status_legal, clock, reset, rsp_valid, rsp_item.status <= sols_pkg::ST_FULL)
   `SOLS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid)
   `SOLS_ASSERT_NOW(a_move_stays_below, clock, reset,
                    op_kind_act == sols_pkg::OP_SHIFT || op_kind_act == sols_pkg::OP_SWAP,
                    lo_ff <= pos_ff)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

   localparam int SLOTS = 64;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   sols_pkg::req_type req_item = '0;
   logic rsp_valid;
   sols_pkg::rsp_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   self_organizing_list_search #(.TABLE_SLOTS(SLOTS)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the table and its registers
   logic [31:0] sh_key [SLOTS];
   logic        sh_valid [SLOTS];
   logic [15:0] sh_hits [SLOTS];
   logic [15:0] sh_run;
   logic [2:0]  cfg_strategy;
   logic [7:0]  cfg_k;
   logic [15:0] cfg_limit;
   logic [6:0]  cfg_window;
   logic [6:0]  cfg_length;

   sols_pkg::rsp_type pending_rsp [$];
   int mismatches = 0;
   int cycles = 0;
   int sent = 0;
   int checked = 0;
   bit allow_idle = 1'b1;

   // Keys are mostly drawn from a small pool so that searches hit often
   logic [31:0] key_pool [16];

   function automatic int used_len();
      return (cfg_length > SLOTS) ? SLOTS : int'(cfg_length);
   endfunction

   function automatic int find_slot(logic [31:0] k);
      for (int i = 0; i < used_len(); i++)
         if (sh_valid[i] && sh_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void swap_slot(int a, int b);
      logic [31:0] tk;
      logic tv;
      logic [15:0] th;
      tk = sh_key[a]; tv = sh_valid[a]; th = sh_hits[a];
      sh_key[a] = sh_key[b]; sh_valid[a] = sh_valid[b]; sh_hits[a] = sh_hits[b];
      sh_key[b] = tk; sh_valid[b] = tv; sh_hits[b] = th;
   endfunction

   function automatic void shift_down(int dst, int src);
      for (int s = src; s > dst; s--) swap_slot(s, s - 1);
   endfunction

   function automatic int k_slot(int pos);
      return (int'(cfg_k) * pos) >> 8;
   endfunction

   // Reorder the shadow table after a hit at pos
   function automatic void reorder_table(int pos);
      int dst;
      case (cfg_strategy)
         sols_pkg::STRAT_MOVE_FRONT: shift_down(0, pos);
         sols_pkg::STRAT_K_SWAP:     swap_slot(k_slot(pos), pos);
         sols_pkg::STRAT_K_MOVE:     shift_down(k_slot(pos), pos);
         sols_pkg::STRAT_COUNT: begin
            if (sh_hits[pos] != 16'hFFFF) sh_hits[pos]++;
            dst = (pos >= int'(sh_hits[pos])) ? pos - int'(sh_hits[pos]) : 0;
            shift_down(dst, pos);
         end
         sols_pkg::STRAT_HYBRID: begin
            if (sh_run < cfg_limit) begin
               shift_down(0, pos);
               if (pos + 1 <= int'(cfg_window)) begin
                  if (sh_run != 16'hFFFF) sh_run++;
               end else begin
                  sh_run = '0;
               end
            end else begin
               swap_slot(k_slot(pos), pos);
            end
         end
         default: if (pos > 0) swap_slot(pos, pos - 1);
      endcase
   endfunction

   function automatic sols_pkg::rsp_type predict_lookup(sols_pkg::req_type r);
      sols_pkg::rsp_type o;
      int hit;
      o = '0;
      case (r.cmd)
         sols_pkg::CMD_SEARCH: begin
            hit = find_slot(r.key);
            if (hit < 0) o.status = sols_pkg::ST_NOT_FOUND;
            else begin
               o.position = hit[5:0];
               reorder_table(hit);
            end
         end
         sols_pkg::CMD_INSERT: begin
            o.status = sols_pkg::ST_FULL;
            for (int i = 0; i < used_len(); i++)
               if (!sh_valid[i]) begin
                  sh_valid[i] = 1'b1;
                  sh_key[i] = r.key;
                  o.status = sols_pkg::ST_OK;
                  o.position = i[5:0];
                  break;
               end
         end
         sols_pkg::CMD_DELETE: begin
            hit = find_slot(r.key);
            if (hit < 0) o.status = sols_pkg::ST_NOT_FOUND;
            else begin
               o.position = hit[5:0];
               sh_valid[hit] = 1'b0;
            end
         end
         default: for (int i = 0; i < SLOTS; i++) sh_hits[i] = '0;
      endcase
      return o;
   endfunction

   // Check each strobed result against the oldest prediction
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result %p", rsp_item);
         end else begin
            sols_pkg::rsp_type e;
            e = pending_rsp.pop_front();
            checked <= checked + 1;
            if (rsp_item.status !== e.status || rsp_item.position !== e.position) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected status %0d pos %0d, got status %0d pos %0d",
                           e.status, e.position, rsp_item.status, rsp_item.position);
            end
         end
      end
   end

   // Hard stop on a hang
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic idle_burst();
      if (allow_idle && $urandom_range(3) == 0)
         repeat ($urandom_range(19, 1)) @(posedge clock);
   endtask

   // Send one command; predict at the accepting edge, then drop start and
   // wait while the block is busy anyway
   task automatic send_item(logic [1:0] c, logic [31:0] k);
      sols_pkg::req_type r;
      r.cmd = c;
      r.key = k;
      idle_burst();
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(predict_lookup(r));
      sent++;
      start <= 1'b0;
      req_item <= '{cmd: 2'($urandom), key: $urandom};
      @(posedge clock);
   endtask

   // Drain results, then allow the block to settle before a write
   task automatic wait_idle();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         sols_pkg::CSR_STRATEGY: cfg_strategy = val[2:0];
         sols_pkg::CSR_K_FRAC:   cfg_k = val[7:0];
         sols_pkg::CSR_RUN_LIM:  cfg_limit = val;
         sols_pkg::CSR_WINDOW:   cfg_window = val[6:0];
         sols_pkg::CSR_LENGTH:   cfg_length = val[6:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(logic [2:0] s, logic [7:0] k, logic [15:0] lim,
                             logic [6:0] win, logic [6:0] len);
      wait_idle();
      write_reg(sols_pkg::CSR_STRATEGY, 16'(s));
      write_reg(sols_pkg::CSR_K_FRAC, 16'(k));
      write_reg(sols_pkg::CSR_RUN_LIM, lim);
      write_reg(sols_pkg::CSR_WINDOW, 16'(win));
      write_reg(sols_pkg::CSR_LENGTH, 16'(len));
   endtask

   function automatic logic [31:0] pick_key();
      return ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(15)];
   endfunction

   // Extremes of the key, every command, and an empty table
   task automatic test_directed();
      send_item(sols_pkg::CMD_SEARCH, 32'h8000_0000);
      send_item(sols_pkg::CMD_DELETE, 32'h7FFF_FFFF);
      send_item(sols_pkg::CMD_INSERT, 32'h8000_0000);
      send_item(sols_pkg::CMD_INSERT, 32'h7FFF_FFFF);
      send_item(sols_pkg::CMD_INSERT, 32'hFFFF_FFFF);
      send_item(sols_pkg::CMD_INSERT, 32'h0000_0000);
      send_item(sols_pkg::CMD_SEARCH, 32'h0000_0000);
      send_item(sols_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
      send_item(sols_pkg::CMD_DELETE, 32'h7FFF_FFFF);
      send_item(sols_pkg::CMD_INSERT, 32'h1234_5678);
      send_item(sols_pkg::CMD_CLEAR, 32'h0);
      // Empty table: nothing found, insert reports full
      set_config(sols_pkg::STRAT_TRANSPOSE, 8'd0, 16'd0, 7'd0, 7'd0);
      send_item(sols_pkg::CMD_SEARCH, 32'h0);
      send_item(sols_pkg::CMD_INSERT, 32'h5);
      send_item(sols_pkg::CMD_DELETE, 32'h0);
      // Length above the table acts as the table size; insert six keys
      set_config(sols_pkg::STRAT_K_MOVE, 8'hFF, 16'hFFFF, 7'd64, 7'd127);
      for (int i = 0; i < 6; i++) send_item(sols_pkg::CMD_INSERT, key_pool[i]);
      send_item(sols_pkg::CMD_SEARCH, key_pool[5]);
      send_item(sols_pkg::CMD_SEARCH, key_pool[4]);
   endtask

   // Random traffic under one setting, mostly well-formed lookups on known keys
   task automatic test_random_phase(int n, logic [2:0] s, logic [7:0] k,
                                    logic [15:0] lim, logic [6:0] win, logic [6:0] len);
      int roll;
      set_config(s, k, lim, win, len);
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (roll < 55) send_item(sols_pkg::CMD_SEARCH, pick_key());
         else if (roll < 80) send_item(sols_pkg::CMD_INSERT, pick_key());
         else if (roll < 97) send_item(sols_pkg::CMD_DELETE, pick_key());
         else send_item(sols_pkg::CMD_CLEAR, $urandom);
      end
   endtask

   // Pause the sender until every result has come back
   task automatic test_drain_pause();
      send_item(sols_pkg::CMD_SEARCH, key_pool[0]);
      send_item(sols_pkg::CMD_INSERT, key_pool[1]);
      while (pending_rsp.size() != 0) @(posedge clock);
      send_item(sols_pkg::CMD_SEARCH, key_pool[1]);
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         sh_key[i] = '0; sh_valid[i] = 1'b0; sh_hits[i] = '0;
      end
      sh_run = '0;
      cfg_strategy = sols_pkg::STRAT_TRANSPOSE; cfg_k = '0; cfg_limit = '0;
      cfg_window = '0; cfg_length = 7'd64;
      key_pool[0] = 32'h0; key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000; key_pool[3] = 32'h7FFF_FFFF;
      for (int i = 4; i < 16; i++) key_pool[i] = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_drain_pause();
      test_random_phase(200, sols_pkg::STRAT_TRANSPOSE, 8'd0, 16'd0, 7'd0, 7'd64);
      test_random_phase(200, sols_pkg::STRAT_MOVE_FRONT, 8'd0, 16'd0, 7'd0, 7'd20);
      test_random_phase(200, sols_pkg::STRAT_K_SWAP, 8'h80, 16'd0, 7'd0, 7'd64);
      test_random_phase(200, sols_pkg::STRAT_K_MOVE, 8'hFF, 16'd0, 7'd0, 7'd12);
      test_random_phase(250, sols_pkg::STRAT_COUNT, 8'd0, 16'd0, 7'd0, 7'd64);
      test_random_phase(250, sols_pkg::STRAT_HYBRID, 8'h55, 16'd4, 7'd3, 7'd16);
      test_random_phase(150, sols_pkg::STRAT_HYBRID, 8'hC0, 16'hFFFF, 7'd127, 7'd64);
      test_random_phase(100, 3'd6, 8'd0, 16'd0, 7'd0, 7'd2);
      // Last stretch with no idling at all
      allow_idle = 1'b0;
      test_random_phase(200, 3'd7, 8'h33, 16'd1, 7'd64, 7'd64);

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("summary: %0d commands sent, %0d results checked across all strategies",
               sent, checked);
      $display("summary: lengths 0 to 127, k and run limit at extremes, %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+design
design/sols_pkg.sv
design/sols_cell.sv
design/self_organizing_list_search.sv
tb/tb_top.sv
